// ===== sv/gdc_pkg.sv =====
`default_nettype none
package gdc_pkg;

  // Divider chain widths: 33-bit dividend, 34-bit divisor, one quotient bit per cell
  localparam int NUM_W = 33;
  localparam int DEN_W = 34;

  localparam logic [30:0] DIST_SAT = 31'h7FFF_FFFF;
  localparam int          ONE_Q    = 65536;

  // Register indexes
  localparam logic [2:0] REG_CAM_POS_X   = 3'd0;
  localparam logic [2:0] REG_CAM_POS_Y   = 3'd1;
  localparam logic [2:0] REG_VIEW_DIR_X  = 3'd2;
  localparam logic [2:0] REG_VIEW_DIR_Y  = 3'd3;
  localparam logic [2:0] REG_CAM_PLANE_X = 3'd4;
  localparam logic [2:0] REG_CAM_PLANE_Y = 3'd5;

  // Item kinds
  localparam logic KIND_MAP_WRITE = 1'b0;
  localparam logic KIND_CAST      = 1'b1;

  localparam logic [31:0] COLOR_NONE    = 32'hFF00_0000;
  localparam logic [31:0] COLOR_RED     = 32'hFF00_00FF;
  localparam logic [31:0] COLOR_GREEN   = 32'hFF00_FF00;
  localparam logic [31:0] COLOR_BLUE    = 32'hFFFF_0000;
  localparam logic [31:0] COLOR_MAGENTA = 32'hFFFF_00FF;
  localparam logic [31:0] MASK_BR       = 32'h00FF_00FF;
  localparam logic [31:0] MASK_G        = 32'h0000_FF00;
  localparam logic [31:0] ALPHA_FULL    = 32'hFF00_0000;
  localparam logic [7:0]  SHADE_Y       = 8'hC0;

  typedef struct packed {
    logic       kind;
    logic [9:0] column;
    logic [5:0] cell_index;
    logic [2:0] cell_value;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  column_out;
    logic [8:0]  wall_top;
    logic [8:0]  wall_bottom;
    logic [31:0] wall_color;
    logic        hit_side;
    logic [2:0]  hit_cell;
    logic [30:0] wall_distance;
    logic        out_of_range;
  } out_item_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] quo;
    logic [DEN_W-1:0] den;
  } div_data_t;

  function automatic logic [31:0] base_color(input logic [2:0] cell_val);
    logic [31:0] c;
    case (cell_val)
      3'd1:    c = COLOR_RED;
      3'd2:    c = COLOR_GREEN;
      3'd3:    c = COLOR_BLUE;
      3'd4:    c = COLOR_MAGENTA;
      default: c = COLOR_NONE;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== sv/gdc_div_cell.sv =====
`default_nettype none
// One restoring step: shift in a dividend bit, subtract if it fits.
module gdc_div_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire gdc_pkg::div_data_t data_i,
  output logic                   valid_o,
  output gdc_pkg::div_data_t     data_o
);

  logic [gdc_pkg::DEN_W:0]   shifted;
  logic                      fits;
  gdc_pkg::div_data_t        data_d;
  gdc_pkg::div_data_t        data_q;
  logic                      valid_q;

  always_comb begin
    shifted     = {data_i.rem, data_i.num[gdc_pkg::NUM_W-1]};
    fits        = shifted >= {1'b0, data_i.den};
    data_d      = data_i;
    data_d.rem  = fits ? gdc_pkg::DEN_W'(shifted - {1'b0, data_i.den})
                       : shifted[gdc_pkg::DEN_W-1:0];
    data_d.num  = {data_i.num[gdc_pkg::NUM_W-2:0], 1'b0};
    data_d.quo  = {data_i.quo[gdc_pkg::NUM_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

// ===== sv/gdc_div_chain.sv =====
`default_nettype none
// Pipelined unsigned divider, NUM_W cells, one item may enter every cycle.
module gdc_div_chain (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  wire logic [gdc_pkg::NUM_W-1:0]   num_i,
  input  wire logic [gdc_pkg::DEN_W-1:0]   den_i,
  output logic                             valid_o,
  output logic [gdc_pkg::NUM_W-1:0]        quo_o
);

  logic               vld [gdc_pkg::NUM_W+1];
  gdc_pkg::div_data_t dat [gdc_pkg::NUM_W+1];

  assign vld[0] = valid_i;
  assign dat[0] = '{rem: '0, num: num_i, quo: '0, den: den_i};

  for (genvar i = 0; i < gdc_pkg::NUM_W; i++) begin : g_cell
    gdc_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[i]),
      .data_i  (dat[i]),
      .valid_o (vld[i+1]),
      .data_o  (dat[i+1])
    );
  end

  assign valid_o = vld[gdc_pkg::NUM_W];
  assign quo_o   = dat[gdc_pkg::NUM_W].quo;

endmodule
`default_nettype wire

// ===== sv/grid_dda_ray_column_caster.sv =====
`default_nettype none
// Cast item: the column position, the ray step deltas and the wall height each pass the
//   33-cell divider chain; the height division is skipped when the distance is zero and
//   the map read is skipped when the ray leaves the grid; at most 4*MAP_SIDE+4 DDA steps.
// Map write item: no result. One item in flight; a held result stalls the next cast.
// Reset: async active low; the map is swept to zero, cell by cell, before the first item
//   is taken. Config registers return to their default camera.
module grid_dda_ray_column_caster #(
  parameter int MAP_SIDE = 8,
  parameter int SCREEN_W = 640,
  parameter int SCREEN_H = 480
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // item input
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire gdc_pkg::in_item_t  in_data_i,
  // result output
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output gdc_pkg::out_item_t      out_data_o,
  // APB config
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int NCELL = MAP_SIDE * MAP_SIDE;
  localparam int AW    = $clog2(NCELL);
  localparam int CW    = $clog2(MAP_SIDE);
  localparam int LIMIT = 4 * MAP_SIDE + 4;
  localparam int NW    = $clog2(LIMIT + 1);
  localparam int HALF  = SCREEN_H / 2;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_XCAM, S_MUL, S_RAY, S_SLX, S_SLY, S_SWT,
    S_FD, S_STEP, S_CHK, S_RD, S_HGT, S_HDIV, S_HWT, S_FIN
  } state_e;

  // ---------------- config registers ----------------
  logic signed [31:0] pos_x_q, pos_y_q, dir_x_q, dir_y_q, plane_x_q, plane_y_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= 32'sd131072;
      pos_y_q   <= 32'sd131072;
      dir_x_q   <= -32'sd65211;
      dir_y_q   <= 32'sd6521;
      plane_x_q <= 32'sd0;
      plane_y_q <= 32'sd43254;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        gdc_pkg::REG_CAM_POS_X:   pos_x_q   <= pwdata;
        gdc_pkg::REG_CAM_POS_Y:   pos_y_q   <= pwdata;
        gdc_pkg::REG_VIEW_DIR_X:  dir_x_q   <= pwdata;
        gdc_pkg::REG_VIEW_DIR_Y:  dir_y_q   <= pwdata;
        gdc_pkg::REG_CAM_PLANE_X: plane_x_q <= pwdata;
        gdc_pkg::REG_CAM_PLANE_Y: plane_y_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      gdc_pkg::REG_CAM_POS_X:   prdata = pos_x_q;
      gdc_pkg::REG_CAM_POS_Y:   prdata = pos_y_q;
      gdc_pkg::REG_VIEW_DIR_X:  prdata = dir_x_q;
      gdc_pkg::REG_VIEW_DIR_Y:  prdata = dir_y_q;
      gdc_pkg::REG_CAM_PLANE_X: prdata = plane_x_q;
      gdc_pkg::REG_CAM_PLANE_Y: prdata = plane_y_q;
      default:                  prdata = '0;
    endcase
  end

  // ---------------- datapath registers ----------------
  state_e             state_q;
  logic [AW-1:0]      clr_q;
  logic [9:0]         col_q;
  logic signed [27:0] xcam_q;
  logic signed [59:0] prod_x_q, prod_y_q;
  logic signed [44:0] rx_q, ry_q;
  logic               got_x_q;
  logic [30:0]        dx_q, dy_q;
  logic [39:0]        sx_q, sy_q;
  logic signed [17:0] cx_q, cy_q;
  logic               nx_q, zx_q, ny_q, zy_q;   // step direction: negative, zero
  logic [NW-1:0]      n_q;
  logic               side_q;
  logic               oor_q;
  logic [2:0]         cell_q;
  logic [30:0]        dp_q;
  logic [33:0]        h_q;
  logic               out_valid_q;
  gdc_pkg::out_item_t out_q;

  // ---------------- map memory ----------------
  logic [2:0]    mem [NCELL];
  logic [2:0]    rd_q;
  logic [AW-1:0] addr_c;
  logic          in_acc;
  logic          map_we;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign map_we     = in_acc && (in_data_i.kind == gdc_pkg::KIND_MAP_WRITE)
                      && (32'(in_data_i.cell_index) < 32'(NCELL));
  assign addr_c     = AW'(AW'(cy_q[CW-1:0]) * AW'(MAP_SIDE)) + AW'(cx_q[CW-1:0]);

  always_ff @(posedge clk_i) begin
    if (state_q == S_CLR) begin
      mem[clr_q] <= 3'd0;
    end else if (map_we) begin
      mem[AW'(in_data_i.cell_index)] <= in_data_i.cell_value;
    end
    rd_q <= mem[addr_c];
  end

  // ---------------- divider chain ----------------
  logic                       div_vld;
  logic [gdc_pkg::NUM_W-1:0]  div_num;
  logic [gdc_pkg::DEN_W-1:0]  div_den;
  logic                       quo_vld;
  logic [gdc_pkg::NUM_W-1:0]  quo;
  logic [44:0]                mx, my;
  logic [33:0]                den_x, den_y;
  logic [30:0]                quo_sat;

  gdc_div_chain u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_vld),
    .num_i   (div_num),
    .den_i   (div_den),
    .valid_o (quo_vld),
    .quo_o   (quo)
  );

  // |r| clamped: anything at or above 2^33 gives a zero quotient for 2^32
  assign mx      = rx_q[44] ? 45'(-rx_q) : 45'(rx_q);
  assign my      = ry_q[44] ? 45'(-ry_q) : 45'(ry_q);
  assign den_x   = (mx[44:33] != '0) ? 34'h2_0000_0000 : mx[33:0];
  assign den_y   = (my[44:33] != '0) ? 34'h2_0000_0000 : my[33:0];
  // zero divisor gives all ones, which saturates too
  assign quo_sat = (quo[32] | quo[31]) ? gdc_pkg::DIST_SAT : quo[30:0];

  always_comb begin
    div_vld = 1'b0;
    div_num = '0;
    div_den = '0;
    case (state_q)
      S_IDLE: begin
        div_vld = in_acc && (in_data_i.kind == gdc_pkg::KIND_CAST);
        div_num = gdc_pkg::NUM_W'({in_data_i.column, 17'd0});
        div_den = gdc_pkg::DEN_W'(SCREEN_W);
      end
      S_SLX: begin
        div_vld = 1'b1;
        div_num = 33'h1_0000_0000;
        div_den = den_x;
      end
      S_SLY: begin
        div_vld = 1'b1;
        div_num = 33'h1_0000_0000;
        div_den = den_y;
      end
      S_HDIV: begin
        div_vld = (dp_q != '0);
        div_num = gdc_pkg::NUM_W'(SCREEN_H * gdc_pkg::ONE_Q);
        div_den = gdc_pkg::DEN_W'(dp_q);
      end
      default: ;
    endcase
  end

  // ---------------- combinational helpers ----------------
  logic signed [59:0] pmul_x, pmul_y;
  logic [16:0]        fx, fy;
  logic [47:0]        fdx, fdy;
  logic               inb;
  logic [39:0]        dsel;
  logic [34:0]        hh, y0_c, y1_c, sum_c;
  logic [31:0]        col_base, br_c, g_c, color_c;
  logic [39:0]        br_m, g_m;

  assign pmul_x = plane_x_q * xcam_q;
  assign pmul_y = plane_y_q * xcam_q;
  assign fx     = rx_q[44] ? {1'b0, pos_x_q[15:0]} : 17'h1_0000 - {1'b0, pos_x_q[15:0]};
  assign fy     = ry_q[44] ? {1'b0, pos_y_q[15:0]} : 17'h1_0000 - {1'b0, pos_y_q[15:0]};
  assign fdx    = dx_q * fx;
  assign fdy    = dy_q * fy;
  assign inb    = !cx_q[17] && !cy_q[17]
                  && (cx_q < 18'(MAP_SIDE)) && (cy_q < 18'(MAP_SIDE));
  assign dsel   = side_q ? (sy_q - 40'(dy_q)) : (sx_q - 40'(dx_q));

  // wall span
  assign hh    = 35'(h_q >> 1);
  assign sum_c = 35'(HALF) + hh;
  assign y0_c  = (hh > 35'(HALF)) ? '0 : 35'(HALF) - hh;
  assign y1_c  = (sum_c > 35'(SCREEN_H - 1)) ? 35'(SCREEN_H - 1) : sum_c;

  // color, darkened to 0xC0/0x100 on y sides
  assign col_base = gdc_pkg::base_color(cell_q);
  assign br_m     = 40'(col_base & gdc_pkg::MASK_BR) * 40'(gdc_pkg::SHADE_Y);
  assign g_m      = 40'(col_base & gdc_pkg::MASK_G) * 40'(gdc_pkg::SHADE_Y);
  assign br_c     = 32'(br_m >> 8) & gdc_pkg::MASK_BR;
  assign g_c      = 32'(g_m >> 8) & gdc_pkg::MASK_G;
  always_comb begin
    if (oor_q) begin
      color_c = '0;
    end else if (side_q) begin
      color_c = gdc_pkg::ALPHA_FULL | br_c | g_c;
    end else begin
      color_c = col_base;
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      got_x_q     <= 1'b0;
    end else begin
      // in S_FIN the result register is handled below
      if (out_valid_q && out_ready_i && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(NCELL - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc && (in_data_i.kind == gdc_pkg::KIND_CAST)) begin
            col_q   <= in_data_i.column;
            state_q <= S_XCAM;
          end
        end
        S_XCAM: begin
          if (quo_vld) begin
            xcam_q  <= signed'(28'(quo)) - 28'sd65536;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_x_q <= pmul_x;
          prod_y_q <= pmul_y;
          state_q  <= S_RAY;
        end
        S_RAY: begin
          rx_q    <= 45'(dir_x_q) + 45'(prod_x_q >>> 16);
          ry_q    <= 45'(dir_y_q) + 45'(prod_y_q >>> 16);
          state_q <= S_SLX;
        end
        S_SLX: begin
          got_x_q <= 1'b0;
          state_q <= S_SLY;
        end
        S_SLY: state_q <= S_SWT;
        S_SWT: begin
          if (quo_vld) begin
            if (!got_x_q) begin
              dx_q    <= quo_sat;
              got_x_q <= 1'b1;
            end else begin
              dy_q    <= quo_sat;
              state_q <= S_FD;
            end
          end
        end
        S_FD: begin
          sx_q    <= 40'(fdx >> 16);
          sy_q    <= 40'(fdy >> 16);
          cx_q    <= 18'(pos_x_q >>> 16);
          cy_q    <= 18'(pos_y_q >>> 16);
          nx_q    <= rx_q[44];
          zx_q    <= (rx_q == '0);
          ny_q    <= ry_q[44];
          zy_q    <= (ry_q == '0);
          n_q     <= '0;
          side_q  <= 1'b0;
          oor_q   <= 1'b0;
          cell_q  <= '0;
          state_q <= S_STEP;
        end
        S_STEP: begin
          n_q <= n_q + 1'b1;
          if (sx_q < sy_q) begin
            sx_q   <= sx_q + 40'(dx_q);
            cx_q   <= zx_q ? cx_q : (nx_q ? cx_q - 18'sd1 : cx_q + 18'sd1);
            side_q <= 1'b0;
          end else begin
            sy_q   <= sy_q + 40'(dy_q);
            cy_q   <= zy_q ? cy_q : (ny_q ? cy_q - 18'sd1 : cy_q + 18'sd1);
            side_q <= 1'b1;
          end
          state_q <= S_CHK;
        end
        S_CHK: begin
          if (!inb) begin
            oor_q   <= 1'b1;
            state_q <= S_HGT;
          end else begin
            state_q <= S_RD;
          end
        end
        S_RD: begin
          if (rd_q != '0) begin
            cell_q  <= rd_q;
            state_q <= S_HGT;
          end else if (n_q == NW'(LIMIT)) begin
            oor_q   <= 1'b1;
            state_q <= S_HGT;
          end else begin
            state_q <= S_STEP;
          end
        end
        S_HGT: begin
          // distance is never negative: the last step added the delta
          dp_q    <= (dsel > 40'(gdc_pkg::DIST_SAT)) ? gdc_pkg::DIST_SAT : dsel[30:0];
          state_q <= S_HDIV;
        end
        S_HDIV: begin
          if (dp_q == '0) begin
            h_q     <= 34'(2 * SCREEN_H);
            state_q <= S_FIN;
          end else begin
            state_q <= S_HWT;
          end
        end
        S_HWT: begin
          if (quo_vld) begin
            h_q     <= 34'(quo);
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.column_out    <= col_q;
            out_q.wall_top      <= y0_c[8:0];
            out_q.wall_bottom   <= y1_c[8:0];
            out_q.wall_color    <= color_c;
            out_q.hit_side      <= side_q;
            out_q.hit_cell      <= oor_q ? 3'd0 : cell_q;
            out_q.wall_distance <= dp_q;
            out_q.out_of_range  <= oor_q;
            out_valid_q         <= 1'b1;
            state_q             <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== tb/sv/ray_cast_checker.sv =====
`default_nettype none
module ray_cast_checker #(
  parameter int MAP_SIDE = 8,
  parameter int SCREEN_W = 640,
  parameter int SCREEN_H = 480
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire gdc_pkg::in_item_t  in_data_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire gdc_pkg::out_item_t out_data_i,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  input  wire logic               pready,
  output int                      fail_count_o,
  output int                      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import gdc_pkg::*;

  localparam longint ONE = 65536;
  localparam longint SAT = 64'h7FFF_FFFF;

  logic [2:0] grid_model [MAP_SIDE*MAP_SIDE];
  longint pos_x, pos_y, dir_x, dir_y, plane_x, plane_y;
  out_item_t expected_spans[$];

  function automatic longint floor_div_q(longint a);
    longint q;
    q = a / ONE;
    if ((a % ONE) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint grid_step(longint r);
    longint m, d;
    m = r < 0 ? -r : r;
    if (m == 0) return SAT;
    d = (64'sd1 <<< 32) / m;
    return d > SAT ? SAT : d;
  endfunction

  function automatic longint edge_dist(longint p, longint r, longint dl);
    longint fr, f;
    fr = p & 64'hFFFF;
    f = r < 0 ? fr : ONE - fr;
    return (dl * f) / ONE;
  endfunction

  function automatic out_item_t cast_column(logic [9:0] col);
    out_item_t o;
    longint xc, rx, ry, dx, dy, sx, sy, cx, cy, dp, h, y0, y1, stx, sty;
    int side, n;
    logic [2:0] hit_val;
    bit oor;
    logic [31:0] c, br, g;
    side = 0; hit_val = 0; oor = 0; c = 0;
    xc = (longint'(col) * 2 * ONE) / SCREEN_W - ONE;
    rx = dir_x + floor_div_q(plane_x * xc);
    ry = dir_y + floor_div_q(plane_y * xc);
    dx = grid_step(rx);
    dy = grid_step(ry);
    sx = edge_dist(pos_x, rx, dx);
    sy = edge_dist(pos_y, ry, dy);
    cx = floor_div_q(pos_x);
    cy = floor_div_q(pos_y);
    stx = rx < 0 ? -1 : (rx > 0 ? 1 : 0);
    sty = ry < 0 ? -1 : (ry > 0 ? 1 : 0);
    for (n = 0; n < 4*MAP_SIDE+4; n++) begin
      if (sx < sy) begin
        sx += dx; cx += stx; side = 0;
      end else begin
        sy += dy; cy += sty; side = 1;
      end
      if (cx < 0 || cx >= MAP_SIDE || cy < 0 || cy >= MAP_SIDE) begin
        oor = 1;
        break;
      end
      hit_val = grid_model[cy*MAP_SIDE + cx];
      if (hit_val != 0) break;
    end
    if (hit_val == 0) oor = 1;
    if (oor) hit_val = 0;
    if (!oor) begin
      case (hit_val)
        3'd1: c = COLOR_RED;
        3'd2: c = COLOR_GREEN;
        3'd3: c = COLOR_BLUE;
        3'd4: c = COLOR_MAGENTA;
        default: c = COLOR_NONE;
      endcase
      if (side == 1) begin
        br = ((c & MASK_BR) * SHADE_Y) >> 8;
        g  = ((c & MASK_G) * SHADE_Y) >> 8;
        c  = ALPHA_FULL | (br & MASK_BR) | (g & MASK_G);
      end
    end
    dp = side ? sy - dy : sx - dx;
    if (dp < 0) dp = 0;
    if (dp > SAT) dp = SAT;
    h = dp == 0 ? SCREEN_H * 2 : (longint'(SCREEN_H) * ONE) / dp;
    y0 = SCREEN_H/2 - h/2;
    if (y0 < 0) y0 = 0;
    y1 = SCREEN_H/2 + h/2;
    if (y1 > SCREEN_H-1) y1 = SCREEN_H-1;
    o.column_out = col;
    o.wall_top = y0[8:0];
    o.wall_bottom = y1[8:0];
    o.wall_color = c;
    o.hit_side = side[0];
    o.hit_cell = hit_val;
    o.wall_distance = dp[30:0];
    o.out_of_range = oor;
    return o;
  endfunction

  assign pending_o = expected_spans.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e;
    if (!rst_ni) begin
      foreach (grid_model[i]) grid_model[i] = '0;
      pos_x = 131072; pos_y = 131072;
      dir_x = -65211; dir_y = 6521;
      plane_x = 0; plane_y = 43254;
      expected_spans.delete();
      fail_count_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_CAM_POS_X:   pos_x   = longint'($signed(pwdata));
          REG_CAM_POS_Y:   pos_y   = longint'($signed(pwdata));
          REG_VIEW_DIR_X:  dir_x   = longint'($signed(pwdata));
          REG_VIEW_DIR_Y:  dir_y   = longint'($signed(pwdata));
          REG_CAM_PLANE_X: plane_x = longint'($signed(pwdata));
          REG_CAM_PLANE_Y: plane_y = longint'($signed(pwdata));
          default: ;
        endcase
      end
      // results compared before the new item so a same-edge cast can't be confused
      if (out_valid_i && out_ready_i) begin
        if (expected_spans.size() == 0) begin
          $error("result with nothing expected: %p", out_data_i);
          fail_count_o++;
        end else begin
          e = expected_spans.pop_front();
          if (e.column_out != out_data_i.column_out) begin
            $error("column_out exp %0d got %0d", e.column_out, out_data_i.column_out);
            fail_count_o++;
          end
          if (e.wall_top != out_data_i.wall_top) begin
            $error("wall_top exp %0d got %0d", e.wall_top, out_data_i.wall_top);
            fail_count_o++;
          end
          if (e.wall_bottom != out_data_i.wall_bottom) begin
            $error("wall_bottom exp %0d got %0d", e.wall_bottom, out_data_i.wall_bottom);
            fail_count_o++;
          end
          if (e.wall_color != out_data_i.wall_color) begin
            $error("wall_color exp %h got %h", e.wall_color, out_data_i.wall_color);
            fail_count_o++;
          end
          if (e.hit_side != out_data_i.hit_side) begin
            $error("hit_side exp %0d got %0d", e.hit_side, out_data_i.hit_side);
            fail_count_o++;
          end
          if (e.hit_cell != out_data_i.hit_cell) begin
            $error("hit_cell exp %0d got %0d", e.hit_cell, out_data_i.hit_cell);
            fail_count_o++;
          end
          if (e.wall_distance != out_data_i.wall_distance) begin
            $error("wall_distance exp %h got %h", e.wall_distance,
                   out_data_i.wall_distance);
            fail_count_o++;
          end
          if (e.out_of_range != out_data_i.out_of_range) begin
            $error("out_of_range exp %0d got %0d", e.out_of_range,
                   out_data_i.out_of_range);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.kind == KIND_CAST)
          expected_spans.push_back(cast_column(in_data_i.column));
        else if (in_data_i.cell_index < MAP_SIDE*MAP_SIDE)
          grid_model[in_data_i.cell_index] = in_data_i.cell_value;
      end
    end
  end
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gdc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_data_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, pending;
  longint cycle_count = 0;
  // receiver mode: 0 random stalls, 1 always ready, 2 long hold-off
  int sink_mode = 0;

  localparam longint CYCLE_LIMIT = 2_000_000;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  grid_dda_ray_column_caster DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ray_cast_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // timeout watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: own stall pattern; in mode 2 it holds off for a long stretch
  always @(posedge clk_i) begin
    int hold;
    if (sink_mode == 2) begin
      out_ready_i <= 1'b0;
      for (hold = 0; hold < 2000; hold++) @(posedge clk_i);
      sink_mode = 0;
    end else if (sink_mode == 1)
      out_ready_i <= 1'b1;
    else
      out_ready_i <= ($urandom_range(0, 3) != 0);
  end

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // one item, held until accepted; bursts handled by caller gaps
  task automatic send_item(input in_item_t it);
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic idle_cycles(input int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic write_cell(input int idx, input int val);
    in_item_t it;
    it = '0;
    it.kind = KIND_MAP_WRITE;
    it.cell_index = idx[5:0];
    it.cell_value = val[2:0];
    it.column = 10'($urandom);
    send_item(it);
  endtask

  task automatic cast(input int col);
    in_item_t it;
    it.kind = KIND_CAST;
    it.column = col[9:0];
    it.cell_index = 6'($urandom);
    it.cell_value = 3'($urandom);
    send_item(it);
  endtask

  // drain the expected results, then let the clock run on before the next phase
  task automatic settle();
    idle_cycles(1);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic set_camera(input logic [31:0] px, py, dx, dy, qx, qy);
    apb_write(REG_CAM_POS_X, px);
    apb_write(REG_CAM_POS_Y, py);
    apb_write(REG_VIEW_DIR_X, dx);
    apb_write(REG_VIEW_DIR_Y, dy);
    apb_write(REG_CAM_PLANE_X, qx);
    apb_write(REG_CAM_PLANE_Y, qy);
  endtask

  function automatic logic [31:0] rand_pos();
    return 32'($urandom_range(0, 8*65536 - 1));
  endfunction

  function automatic logic [31:0] rand_dir();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return $urandom;
      default: return 32'($signed($urandom_range(0, 262144)) - 131072);
    endcase
  endfunction

  initial begin
    int i, n, burst, phase;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // wait out the map sweep
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);

    // directed: empty map at default camera, column extremes and beyond-screen
    cast(0); cast(639); cast(320); cast(1023);
    // border walls of every type, including types 5 to 7, plus an ignored-free index 63
    for (i = 0; i < 8; i++) write_cell(i, 1 + (i % 7));
    for (i = 0; i < 8; i++) write_cell(56 + i, 4);
    for (i = 0; i < 8; i++) write_cell(i*8, 2);
    write_cell(63, 7);
    cast(0); cast(639); cast(320); cast(1023);
    settle();

    // extreme camera: zero components, extreme positions
    set_camera(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0);
    cast(0); cast(320);
    settle();
    set_camera(32'h0003_8000, 32'h0003_8000, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h8000_0000, 32'h7FFF_FFFF);
    cast(0); cast(639); cast(320);
    settle();

    // long receiver hold-off while items keep coming
    set_camera(32'h0002_0000, 32'h0002_0000, 32'hFFFF_0145, 32'd6521, 32'd0, 32'd43254);
    sink_mode = 2;
    for (i = 0; i < 20; i++) cast($urandom_range(0, 639));
    settle();
    sink_mode = 0;

    // random phases: new camera, then bursts that mix map writes and casts
    for (phase = 0; phase < 12; phase++) begin
      set_camera(rand_pos(), rand_pos(), rand_dir(), rand_dir(), rand_dir(), rand_dir());
      sink_mode = (phase % 4 == 3) ? 1 : 0;
      n = 0;
      while (n < 46) begin
        burst = $urandom_range(1, 8);
        for (i = 0; i < burst; i++) begin
          if ($urandom_range(0, 3) == 0)
            write_cell($urandom_range(0, 63), $urandom_range(0, 7));
          else
            cast($urandom_range(0, 15) == 0 ? $urandom_range(0, 1023)
                                            : $urandom_range(0, 639));
          n++;
        end
        if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 60));
      end
      settle();
    end

    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire
